// File: sv/assert_macros.svh
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define MBAF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MBAF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define MBAF_ASSERT(lbl, clk, rst_n, prop)
`define MBAF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: sv/mbaf_pkg.sv
package mbaf_pkg;

    typedef enum logic [2:0] {
        FN_RD_HOLD  = 3'd0,
        FN_RD_INPUT = 3'd1,
        FN_WR_COIL  = 3'd2,
        FN_WR_MULTI = 3'd3,
        FN_DATA     = 3'd4
    } func_t;

    localparam logic [7:0]  CODE_RD_HOLD  = 8'h03;
    localparam logic [7:0]  CODE_RD_INPUT = 8'h04;
    localparam logic [7:0]  CODE_WR_COIL  = 8'h05;
    localparam logic [7:0]  CODE_WR_MULTI = 8'h10;

    localparam logic [7:0]  CH_COLON   = 8'h3A;
    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [7:0]  CH_LF      = 8'h0A;
    localparam logic [7:0]  HEX_DIGIT0 = 8'h30;
    localparam logic [7:0]  HEX_ALPHA  = 8'h41;
    localparam logic [15:0] COIL_ON_VAL = 16'hFF00;

    localparam int CMD_BYTES   = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic                      start;
        logic                      close;
        logic [2:0]                nbytes;
        logic [CMD_BYTES-1:0][7:0] payload;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COLON,
        ST_HI,
        ST_LO,
        ST_LRC_HI,
        ST_LRC_LO,
        ST_CR,
        ST_LF
    } emit_state_t;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return HEX_DIGIT0 + {4'd0, v};
        end else begin
            return HEX_ALPHA + {4'd0, v - 4'd10};
        end
    endfunction

endpackage

// File: sv/mbaf_front.sv
`include "assert_macros.svh"

module mbaf_front
    import mbaf_pkg::*;
#(
    parameter int MAX_WRITE_WORDS = 123
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  q_status_t   q_status,
    output logic        push,
    output cmd_t        push_cmd
);

    localparam logic [6:0] MAX_Q = 7'(MAX_WRITE_WORDS);

    logic [7:0]  slave_addr_reg;
    logic        frame_open_reg, frame_open_next;
    logic [6:0]  words_left_reg, words_left_next;

    logic [15:0] ref_in;
    logic [6:0]  qty_in;
    logic        coil_in;
    logic [15:0] word_in;
    logic [6:0]  qty_clamp;
    logic [15:0] coil_val;
    logic        accept;
    logic        push_ok;

    assign ref_in  = s_tdata[15:0];
    assign qty_in  = s_tdata[22:16];
    assign coil_in = s_tdata[23];
    assign word_in = s_tdata[39:24];

    assign qty_clamp = (qty_in > MAX_Q) ? MAX_Q : qty_in;
    assign coil_val  = coil_in ? COIL_ON_VAL : 16'd0;

    assign s_tready  = !q_status.full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        push_cmd        = '0;
        push_ok         = 1'b0;
        frame_open_next = frame_open_reg;
        words_left_next = words_left_reg;
        unique case (s_tuser) inside
            FN_RD_HOLD, FN_RD_INPUT: begin
                push_ok            = 1'b1;
                push_cmd.start     = 1'b1;
                push_cmd.close     = 1'b1;
                push_cmd.nbytes    = 3'd6;
                push_cmd.payload[0] = slave_addr_reg;
                push_cmd.payload[1] = (s_tuser == FN_RD_HOLD) ? CODE_RD_HOLD : CODE_RD_INPUT;
                push_cmd.payload[2] = ref_in[15:8];
                push_cmd.payload[3] = ref_in[7:0];
                push_cmd.payload[4] = 8'd0;
                push_cmd.payload[5] = {1'b0, qty_in};
                frame_open_next    = 1'b0;
                words_left_next    = 7'd0;
            end
            FN_WR_COIL: begin
                push_ok            = 1'b1;
                push_cmd.start     = 1'b1;
                push_cmd.close     = 1'b1;
                push_cmd.nbytes    = 3'd6;
                push_cmd.payload[0] = slave_addr_reg;
                push_cmd.payload[1] = CODE_WR_COIL;
                push_cmd.payload[2] = ref_in[15:8];
                push_cmd.payload[3] = ref_in[7:0];
                push_cmd.payload[4] = coil_val[15:8];
                push_cmd.payload[5] = coil_val[7:0];
                frame_open_next    = 1'b0;
                words_left_next    = 7'd0;
            end
            FN_WR_MULTI: begin
                push_ok            = 1'b1;
                push_cmd.start     = 1'b1;
                push_cmd.close     = (qty_clamp == 7'd0);
                push_cmd.nbytes    = 3'd7;
                push_cmd.payload[0] = slave_addr_reg;
                push_cmd.payload[1] = CODE_WR_MULTI;
                push_cmd.payload[2] = ref_in[15:8];
                push_cmd.payload[3] = ref_in[7:0];
                push_cmd.payload[4] = 8'd0;
                push_cmd.payload[5] = {1'b0, qty_clamp};
                push_cmd.payload[6] = {qty_clamp, 1'b0};
                frame_open_next    = (qty_clamp != 7'd0);
                words_left_next    = qty_clamp;
            end
            FN_DATA: begin
                if (frame_open_reg) begin
                    push_ok            = 1'b1;
                    push_cmd.close     = (words_left_reg == 7'd1);
                    push_cmd.nbytes    = 3'd2;
                    push_cmd.payload[0] = word_in[15:8];
                    push_cmd.payload[1] = word_in[7:0];
                    frame_open_next    = (words_left_reg != 7'd1);
                    words_left_next    = words_left_reg - 7'd1;
                end
            end
            default: begin
                push_ok = 1'b0;
            end
        endcase
    end

    assign push = accept && push_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr_reg <= 8'd1;
            frame_open_reg <= 1'b0;
            words_left_reg <= 7'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                slave_addr_reg <= cfg_data;
            end
            if (accept) begin
                frame_open_reg <= frame_open_next;
                words_left_reg <= words_left_next;
            end
        end
    end

    `MBAF_ASSERT(a_open_has_words, aclk, aresetn, frame_open_reg |-> (words_left_reg != 7'd0))

endmodule

// File: sv/mbaf_queue.sv
`include "assert_macros.svh"

module mbaf_queue
    import mbaf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      pop_cmd,
    output q_status_t status
);

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_cmd      = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `MBAF_ASSERT(a_no_pop_empty, aclk, aresetn, pop |-> !status.empty)
    `MBAF_ASSERT(a_no_push_full, aclk, aresetn, push |-> !status.full)

endmodule

// File: sv/mbaf_back.sv
`include "assert_macros.svh"

module mbaf_back
    import mbaf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  q_status_t  q_status,
    input  cmd_t       pop_cmd,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    emit_state_t state_reg, state_next;
    cmd_t        cur_reg, cur_next;
    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  lrc_reg, lrc_next;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tlast_reg;

    logic        emit;
    logic        done;
    logic        last;
    logic [7:0]  ch;
    logic [7:0]  cur_byte;
    logic [7:0]  lrc_neg;

    assign emit     = (state_reg != ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign cur_byte = cur_reg.payload[idx_reg];
    assign lrc_neg  = ~lrc_reg + 8'd1;

    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        lrc_next   = lrc_reg;
        pop        = 1'b0;
        done       = 1'b0;
        last       = 1'b0;
        ch         = CH_COLON;
        unique case (state_reg)
            ST_IDLE: begin
                done = 1'b1;
            end
            ST_COLON: begin
                ch = CH_COLON;
                if (emit) begin
                    state_next = ST_HI;
                end
            end
            ST_HI: begin
                ch = hex_char(cur_byte[7:4]);
                if (emit) begin
                    state_next = ST_LO;
                end
            end
            ST_LO: begin
                ch = hex_char(cur_byte[3:0]);
                if (emit) begin
                    lrc_next = lrc_reg + cur_byte;
                    if (idx_reg + 3'd1 != cur_reg.nbytes) begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = ST_HI;
                    end else if (cur_reg.close) begin
                        state_next = ST_LRC_HI;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            ST_LRC_HI: begin
                ch = hex_char(lrc_neg[7:4]);
                if (emit) begin
                    state_next = ST_LRC_LO;
                end
            end
            ST_LRC_LO: begin
                ch = hex_char(lrc_neg[3:0]);
                if (emit) begin
                    state_next = ST_CR;
                end
            end
            ST_CR: begin
                ch = CH_CR;
                if (emit) begin
                    state_next = ST_LF;
                end
            end
            ST_LF: begin
                ch   = CH_LF;
                last = 1'b1;
                if (emit) begin
                    done = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (done) begin
            if (!q_status.empty) begin
                pop      = 1'b1;
                cur_next = pop_cmd;
                idx_next = 3'd0;
                if (pop_cmd.start) begin
                    lrc_next   = 8'd0;
                    state_next = ST_COLON;
                end else begin
                    state_next = ST_HI;
                end
            end else begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= 3'd0;
            lrc_reg      <= 8'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            lrc_reg   <= lrc_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (emit) begin
            m_tdata_reg <= ch;
            m_tlast_reg <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `MBAF_ASSERT(a_last_is_lf, aclk, aresetn, (m_tvalid && m_tlast) |-> (m_tdata == CH_LF))
    `MBAF_ASSERT(a_lrc_only_close, aclk, aresetn, (state_reg == ST_LRC_HI) |-> cur_reg.close)

endmodule

// File: sv/modbus_ascii_request_framer_top.sv
// Throughput: at most one character per cycle; m_tready low stalls the serializer, and an empty queue idles it.
// A 4-entry command queue decouples acceptance from the character serializer.
// Reset: synchronous, active low; clears the queue, frame state and LRC, slave address to 1.
module modbus_ascii_request_framer_top
    import mbaf_pkg::*;
#(
    parameter int MAX_WRITE_WORDS = 123
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // reference[15:0], quantity[22:16], coil_on[23], word[39:24]
    input  logic [2:0]  s_tuser,   // func[2:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // ascii_char[7:0]
    output logic        m_tlast
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      pop_cmd;

    mbaf_front #(
        .MAX_WRITE_WORDS(MAX_WRITE_WORDS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    mbaf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .pop_cmd (pop_cmd),
        .status  (q_status)
    );

    mbaf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_status(q_status),
        .pop_cmd (pop_cmd),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

// File: tb/modbus_ascii_request_framer_top_tb.sv
module modbus_ascii_request_framer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbaf_pkg::*;

    localparam int         WRITE_WORDS_MAX = 123;
    localparam int         IDLE_PCT        = 31;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         SETTLE_CYCLES   = 20;
    localparam int         DRAIN_CYCLES    = 40;
    localparam int         WATCHDOG_LIMIT  = 3000;
    localparam int         PHASE_QUOTA     = 70;
    localparam logic [2:0] FN_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FN_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic [2:0]  fn;
        logic [15:0] reference;
        logic [6:0]  qty;
        logic        coil_on;
        logic [15:0] word;
    } request_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } frame_char_t;

    typedef struct {
        request_t req;
        string    golden;
        bit       closes;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // reference[15:0], quantity[22:16], coil_on[23], word[39:24]
    logic [2:0]  s_tuser;   // func[2:0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // ascii_char[7:0]
    logic        m_tlast;

    logic [7:0]  dev_addr;
    logic [7:0]  lrc_acc;
    logic [6:0]  words_due;
    logic        awaiting_words;
    frame_char_t exp_chars[$];
    directed_row_t directed_rows[$];

    int errors       = 0;
    int quiet_cycles = 0;
    bit gaps_on      = 1'b1;
    bit hold_req     = 1'b0;

    modbus_ascii_request_framer_top #(
        .MAX_WRITE_WORDS(WRITE_WORDS_MAX)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] nibble_ascii(input logic [3:0] v);
        if (v < 4'd10) begin
            return HEX_DIGIT0 + 8'(v);
        end
        return HEX_ALPHA + 8'(v - 4'd10);
    endfunction

    task automatic emit_char(input logic [7:0] c, input logic last);
        exp_chars.push_back(frame_char_t'{ch: c, last: last});
    endtask

    task automatic emit_byte(input logic [7:0] b);
        emit_char(nibble_ascii(b[7:4]), 1'b0);
        emit_char(nibble_ascii(b[3:0]), 1'b0);
        lrc_acc = lrc_acc + b;
    endtask

    task automatic emit_close();
        logic [7:0] lrc;
        lrc = ~lrc_acc + 8'd1;
        emit_char(nibble_ascii(lrc[7:4]), 1'b0);
        emit_char(nibble_ascii(lrc[3:0]), 1'b0);
        emit_char(CH_CR, 1'b0);
        emit_char(CH_LF, 1'b1);
        lrc_acc        = 8'd0;
        words_due      = 7'd0;
        awaiting_words = 1'b0;
    endtask

    task automatic predict_request(input request_t r);
        logic [6:0] n;
        if (r.fn == FN_DATA) begin
            if (!awaiting_words) begin
                return;
            end
            emit_byte(r.word[15:8]);
            emit_byte(r.word[7:0]);
            words_due = words_due - 7'd1;
            if (words_due == 7'd0) begin
                emit_close();
            end
            return;
        end
        if (r.fn > FN_DATA) begin
            return;
        end
        lrc_acc        = 8'd0;
        words_due      = 7'd0;
        awaiting_words = 1'b0;
        emit_char(CH_COLON, 1'b0);
        emit_byte(dev_addr);
        case (r.fn)
            FN_RD_HOLD:  emit_byte(CODE_RD_HOLD);
            FN_RD_INPUT: emit_byte(CODE_RD_INPUT);
            FN_WR_COIL:  emit_byte(CODE_WR_COIL);
            default:     emit_byte(CODE_WR_MULTI);
        endcase
        emit_byte(r.reference[15:8]);
        emit_byte(r.reference[7:0]);
        if (r.fn == FN_RD_HOLD || r.fn == FN_RD_INPUT) begin
            emit_byte(8'd0);
            emit_byte({1'b0, r.qty});
            emit_close();
        end else if (r.fn == FN_WR_COIL) begin
            emit_byte(r.coil_on ? COIL_ON_VAL[15:8] : 8'd0);
            emit_byte(r.coil_on ? COIL_ON_VAL[7:0] : 8'd0);
            emit_close();
        end else begin
            n = (r.qty > WRITE_WORDS_MAX) ? 7'(WRITE_WORDS_MAX) : r.qty;
            emit_byte(8'd0);
            emit_byte({1'b0, n});
            emit_byte({n, 1'b0});
            if (n == 7'd0) begin
                emit_close();
            end else begin
                words_due      = n;
                awaiting_words = 1'b1;
            end
        end
    endtask

    function automatic request_t random_request(input logic [2:0] fn);
        request_t r;
        r.fn        = fn;
        r.reference = 16'($urandom);
        r.qty       = 7'($urandom_range(0, 127));
        r.coil_on   = 1'($urandom_range(0, 1));
        r.word      = 16'($urandom);
        return r;
    endfunction

    task automatic add_row(input logic [2:0] fn, input logic [15:0] reference,
                           input logic [6:0] qty, input logic coil_on,
                           input logic [15:0] word, input string golden, input bit closes);
        directed_row_t row;
        row.req    = '{fn: fn, reference: reference, qty: qty, coil_on: coil_on, word: word};
        row.golden = golden;
        row.closes = closes;
        directed_rows.push_back(row);
    endtask

    task automatic send_item(input request_t r, input string golden = "",
                             input bit golden_closes = 1'b0);
        int base;
        @(negedge aclk);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.word, r.coil_on, r.qty, r.reference};
        s_tuser  <= r.fn;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        base = exp_chars.size();
        predict_request(r);
        if (golden.len() != 0) begin
            while (exp_chars.size() > base) void'(exp_chars.pop_back());
            for (int i = 0; i < golden.len(); i++) begin
                emit_char(golden[i], 1'b0);
            end
            if (golden_closes) begin
                emit_char(CH_CR, 1'b0);
                emit_char(CH_LF, 1'b1);
            end
        end
    endtask

    task automatic write_slave_address(input logic [7:0] a);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (exp_chars.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= a;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        dev_addr = a;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_write_run(input logic [6:0] qty, input int words);
        request_t r;
        r     = random_request(FN_WR_MULTI);
        r.qty = qty;
        send_item(r);
        for (int k = 0; k < words; k++) begin
            send_item(random_request(FN_DATA));
        end
    endtask

    task automatic run_random(input int quota);
        int sent;
        int pick;
        int words;
        logic [6:0] qty;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                if ($urandom_range(0, 19) == 0) begin
                    qty = 7'd0;
                end else if ($urandom_range(0, 9) == 0) begin
                    qty = 7'($urandom_range(7, 40));
                end else begin
                    qty = 7'($urandom_range(1, 6));
                end
                words = ($urandom_range(0, 6) == 0) ? $urandom_range(0, qty) : qty;
                send_write_run(qty, words);
                sent += words + 1;
            end else if (pick < 72) begin
                send_item(random_request(3'($urandom_range(FN_RD_HOLD, FN_RD_INPUT))));
                sent++;
            end else if (pick < 86) begin
                send_item(random_request(FN_WR_COIL));
                sent++;
            end else if (pick < 94) begin
                send_item(random_request(FN_DATA));
                sent++;
            end else begin
                send_item(random_request(3'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST))));
            end
        end
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        frame_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_chars.size() == 0) begin
                $display("%0t: unexpected character expected none actual %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = exp_chars.pop_front();
                if (m_tdata !== want.ch) begin
                    $display("%0t: character mismatch expected %h actual %h",
                             $time, want.ch, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: frame end mismatch expected %b actual %b",
                             $time, want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d characters outstanding",
                     $time, exp_chars.size());
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        dev_addr       = 8'd1;
        lrc_acc        = 8'd0;
        words_due      = 7'd0;
        awaiting_words = 1'b0;

        add_row(FN_DATA,     16'h0000, 7'd0,   1'b0, 16'h1234, "", 1'b0);
        add_row(FN_RD_HOLD,  16'h0000, 7'd0,   1'b0, 16'h0000, ":010300000000FC", 1'b1);
        add_row(FN_RD_INPUT, 16'hFFFF, 7'd127, 1'b1, 16'hFFFF, ":0104FFFF007F7E", 1'b1);
        add_row(FN_WR_COIL,  16'h1234, 7'd99,  1'b1, 16'h0000, ":01051234FF00B5", 1'b1);
        add_row(FN_WR_COIL,  16'hABCD, 7'd0,   1'b0, 16'hFFFF, ":0105ABCD000082", 1'b1);
        add_row(3'd5,        16'hFFFF, 7'd127, 1'b1, 16'hFFFF, "", 1'b0);
        add_row(FN_WR_MULTI, 16'h0010, 7'd0,   1'b0, 16'h0000, ":01100010000000DF", 1'b1);
        add_row(FN_WR_MULTI, 16'h5555, 7'd2,   1'b1, 16'hFFFF, "", 1'b0);
        add_row(FN_DATA,     16'hFFFF, 7'd127, 1'b1, 16'h0000, "", 1'b0);
        add_row(FN_DATA,     16'h0000, 7'd0,   1'b0, 16'hFFFF, "", 1'b0);
        add_row(FN_DATA,     16'h0000, 7'd0,   1'b0, 16'h5A5A, "", 1'b0);
        add_row(FN_WR_MULTI, 16'h00FF, 7'd3,   1'b0, 16'h0000, "", 1'b0);
        add_row(FN_DATA,     16'h0000, 7'd3,   1'b0, 16'h1234, "", 1'b0);
        add_row(FN_RD_HOLD,  16'h8001, 7'd64,  1'b1, 16'h0000, "", 1'b0);
        add_row(FN_DATA,     16'h0000, 7'd0,   1'b0, 16'hBEEF, "", 1'b0);
        add_row(FN_WR_MULTI, 16'hAAAA, 7'd127, 1'b0, 16'h0000, ":0110AAAA007BF6", 1'b0);
        add_row(3'd7,        16'h0000, 7'd0,   1'b0, 16'h0000, "", 1'b0);
        add_row(FN_DATA,     16'h0000, 7'd0,   1'b0, 16'hA5A5, "", 1'b0);
        add_row(FN_WR_MULTI, 16'h0000, 7'd124, 1'b1, 16'h0000, "", 1'b0);
        add_row(FN_WR_MULTI, 16'h7FFF, 7'd1,   1'b0, 16'h0000, "", 1'b0);
        add_row(FN_DATA,     16'h0000, 7'd0,   1'b0, 16'h8000, "", 1'b0);
        add_row(3'd6,        16'h0000, 7'd0,   1'b0, 16'h0000, "", 1'b0);
        add_row(FN_WR_MULTI, 16'hFFFF, 7'd123, 1'b1, 16'hFFFF, "", 1'b0);
        add_row(FN_DATA,     16'hFFFF, 7'd127, 1'b1, 16'hFFFF, "", 1'b0);
        add_row(FN_RD_INPUT, 16'h0001, 7'd1,   1'b0, 16'h0000, "", 1'b0);
        add_row(FN_DATA,     16'h0000, 7'd0,   1'b0, 16'h0001, "", 1'b0);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].req, directed_rows[i].golden, directed_rows[i].closes);
        end

        write_slave_address(8'h00);
        hold_req = 1'b1;
        run_random(PHASE_QUOTA);

        write_slave_address(8'hFF);
        gaps_on = 1'b0;
        send_write_run(7'($urandom_range(WRITE_WORDS_MAX, 127)), WRITE_WORDS_MAX + 1);
        run_random(PHASE_QUOTA);
        gaps_on = 1'b1;

        write_slave_address(8'($urandom));
        run_random(PHASE_QUOTA);

        write_slave_address(8'($urandom));
        run_random(PHASE_QUOTA);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (exp_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (exp_chars.size() != 0) begin
            $display("%0t: %0d characters never arrived", $time, exp_chars.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// File: modbus_ascii_request_framer_top.f
+incdir+sv
sv/mbaf_pkg.sv
sv/mbaf_front.sv
sv/mbaf_queue.sv
sv/mbaf_back.sv
sv/modbus_ascii_request_framer_top.sv
tb/modbus_ascii_request_framer_top_tb.sv
